[rtl/date_check_and_weekday_macros.svh]
// ----------------------------------------------------------------------------
// date_check_and_weekday_macros.svh
// Assertion helpers shared by the date checker RTL. Each macro expects clk
// and rst_n (synchronous, active low) to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef DATE_CHECK_AND_WEEKDAY_MACROS_SVH
`define DATE_CHECK_AND_WEEKDAY_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define DCW_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dcw: same-cycle check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define DCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dcw: next-cycle check failed");

`endif

[rtl/dcw_pkg.sv]
// ----------------------------------------------------------------------------
// dcw_pkg
// Types, constants and small lookup functions for the date checker.
// ----------------------------------------------------------------------------
`default_nettype none

package dcw_pkg;

  // Field widths
  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;
  localparam int CNT_W  = 22;
  localparam int WD_W   = 3;
  localparam int MLEN_W = 5;
  localparam int CUM_W  = 9;

  // Calendar window
  localparam int EPOCH_YEAR = 2006;
  localparam int MAX_YEAR   = 9999;

  // Days from 1 Jan year 1 up to the end of the year before the epoch
  localparam int EPOCH_PREV = EPOCH_YEAR - 1;
  localparam int BASE_DAYS  = 365 * EPOCH_PREV + EPOCH_PREV / 4 - EPOCH_PREV / 100
                              + EPOCH_PREV / 400;
  // Weekday of 1 Jan of the epoch year, 0 = Sunday
  localparam int JAN1_WD    = (1 + 5 * (EPOCH_PREV % 4) + 4 * (EPOCH_PREV % 100)
                              + 6 * (EPOCH_PREV % 400)) % 7;
  // Added to the count before the mod-7 fold: JAN1_WD - 1 + 7
  localparam int WD_OFFSET  = JAN1_WD + 6;

  // Reciprocal for floor(p / 100), exact for any 14-bit p
  localparam int RECIP_100 = 5243;
  localparam int RECIP_SH  = 19;
  localparam int PROD_W    = 27;
  localparam int QP_W      = 8;

  localparam logic [MON_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MON_W-1:0] MONTH_DEC = 4'd12;

  // Sequencer step counts
  localparam int ACC_STEPS  = 12;
  localparam int FOLD_STEPS = 4;
  localparam int STEP_W     = 4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_YEAR  = 2'd1,
    ST_MONTH = 2'd2,
    ST_DAY   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_LEAP,
    S_CHECK,
    S_ACC,
    S_FOLD,
    S_OUT
  } state_t;

  typedef struct packed {
    state_t              state;
    logic [STEP_W-1:0]   step;
    logic                load;
  } dcw_ctrl_t;

  // Length of a month in a common year; 0 for codes that are no month
  function automatic logic [MLEN_W-1:0] month_len(input logic [MON_W-1:0] m);
    logic [MLEN_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days of the months before month m in a common year
  function automatic logic [CUM_W-1:0] cum_days(input logic [MON_W-1:0] m);
    logic [CUM_W-1:0] d;
    case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // x mod 7 for a 7-bit x, using 64 = 1 and 8 = 1 (mod 7)
  function automatic logic [WD_W-1:0] mod7(input logic [6:0] x);
    logic [3:0] s;
    logic [3:0] t;
    s = 4'(x[5:3]) + 4'(x[2:0]) + 4'(x[6]);
    t = 4'(s[2:0]) + 4'(s[3]);
    if (t >= 4'd7) begin
      t = t - 4'd7;
    end
    return t[WD_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/dcw_ctrl.sv]
// ----------------------------------------------------------------------------
// dcw_ctrl
// Sequencer: steps a date through divide, leap, check and (if valid) accumulate
// and mod-7 fold phases, loads the result register and drives the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module dcw_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  input  wire logic               chk_ok,
  output dcw_pkg::dcw_ctrl_t      ctrl
);

  dcw_pkg::state_t                 state_r, state_nxt;
  logic [dcw_pkg::STEP_W-1:0]      step_r, step_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            fold_last;
  logic                            work_done;
  logic                            out_free;
  logic                            load;

  assign fold_last = (state_r == dcw_pkg::S_FOLD)
                  && (step_r == dcw_pkg::STEP_W'(dcw_pkg::FOLD_STEPS - 1));
  // A date is finished when it fails a check, closes the fold, or waits in S_OUT
  assign work_done = (state_r == dcw_pkg::S_CHECK && !chk_ok) || fold_last
                  || (state_r == dcw_pkg::S_OUT);
  // The result register takes a new value when empty or draining this cycle
  assign out_free  = !out_valid_r || out_tready;
  assign load      = work_done && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dcw_pkg::S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and step counter
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dcw_pkg::S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = dcw_pkg::S_DIV;
        end
      end
      dcw_pkg::S_DIV:   state_nxt = dcw_pkg::S_LEAP;
      dcw_pkg::S_LEAP:  state_nxt = dcw_pkg::S_CHECK;
      dcw_pkg::S_CHECK: begin
        if (chk_ok) begin
          state_nxt = dcw_pkg::S_ACC;
        end else if (out_free) begin
          state_nxt = dcw_pkg::S_IDLE;
        end else begin
          state_nxt = dcw_pkg::S_OUT;
        end
      end
      dcw_pkg::S_ACC: begin
        if (step_r == dcw_pkg::STEP_W'(dcw_pkg::ACC_STEPS - 1)) begin
          state_nxt = dcw_pkg::S_FOLD;
        end
      end
      dcw_pkg::S_FOLD: begin
        if (fold_last) begin
          state_nxt = out_free ? dcw_pkg::S_IDLE : dcw_pkg::S_OUT;
        end
      end
      // hold the finished date until the result register frees up
      dcw_pkg::S_OUT: begin
        if (out_free) begin
          state_nxt = dcw_pkg::S_IDLE;
        end
      end
      default: state_nxt = dcw_pkg::S_IDLE;
    endcase
    // restart the step count on every phase change
    step_nxt = (state_nxt != state_r) ? '0 : step_r + 1'b1;
    out_valid_nxt = load || (out_valid_r && !out_tready);
  end

  // Outputs
  always_comb begin
    in_tready  = (state_r == dcw_pkg::S_IDLE);
    out_tvalid = out_valid_r;
    ctrl.state = state_r;
    ctrl.step  = step_r;
    ctrl.load  = load;
  end

endmodule

`default_nettype wire

[rtl/dcw_dp.sv]
// ----------------------------------------------------------------------------
// dcw_dp
// Datapath: input capture, reciprocal divide by 100, leap test, range
// checks, the shared add/subtract unit with its accumulator, and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dcw_dp (
  input  wire logic                          clk,
  input  wire dcw_pkg::dcw_ctrl_t            ctrl,
  input  wire logic                          in_tvalid,
  input  wire logic [dcw_pkg::DAY_W-1:0]     day_of_month,
  input  wire logic [dcw_pkg::MON_W-1:0]     month_number,
  input  wire logic [dcw_pkg::YEAR_W-1:0]    year_number,
  output logic                               chk_ok,
  output dcw_pkg::status_t                   status,
  output logic [dcw_pkg::CNT_W-1:0]          day_count,
  output logic [dcw_pkg::WD_W-1:0]           weekday
);

  localparam int CW = dcw_pkg::CNT_W;
  localparam int YW = dcw_pkg::YEAR_W;

  logic [dcw_pkg::DAY_W-1:0]   day_r, day_nxt;
  logic [dcw_pkg::MON_W-1:0]   mon_r, mon_nxt;
  logic [YW-1:0]               year_r, year_nxt;
  logic [dcw_pkg::QP_W-1:0]    qp_r, qp_nxt;
  logic                        leap_r, leap_nxt;
  logic [CW-1:0]               acc_r, acc_nxt;
  dcw_pkg::status_t            status_r, status_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [dcw_pkg::WD_W-1:0]    wd_r, wd_nxt;
  dcw_pkg::status_t            res_status_r, res_status_nxt;
  logic [CW-1:0]               res_count_r, res_count_nxt;
  logic [dcw_pkg::WD_W-1:0]    res_wd_r, res_wd_nxt;

  logic [YW-1:0]               p;
  logic [dcw_pkg::PROD_W-1:0]  prod;
  logic [YW-1:0]               rp;
  logic                        y4, y100, y400;
  logic [dcw_pkg::MLEN_W-1:0]  mlen;
  dcw_pkg::status_t            status_c;
  logic [CW-1:0]               op_a, op_b, sum;
  logic                        sub;

  // p = year - 1; leap and whole-year terms are all taken from p
  assign p    = year_r - YW'(1);
  assign prod = dcw_pkg::PROD_W'(p) * dcw_pkg::PROD_W'(dcw_pkg::RECIP_100);
  assign rp   = p - (YW'({qp_r, 6'b0}) + YW'({qp_r, 5'b0}) + YW'({qp_r, 2'b0}));

  // year divisible by 4 / 100 / 400, seen through p = year - 1
  assign y4   = (p[1:0] == 2'd3);
  assign y100 = (rp == YW'(99));
  assign y400 = y100 && (qp_r[1:0] == 2'd3);

  assign mlen = dcw_pkg::month_len(mon_r)
              + dcw_pkg::MLEN_W'(mon_r == dcw_pkg::MONTH_FEB && leap_r);

  // Year first, then month, then day
  always_comb begin
    if (year_r < YW'(dcw_pkg::EPOCH_YEAR) || year_r > YW'(dcw_pkg::MAX_YEAR)) begin
      status_c = dcw_pkg::ST_YEAR;
    end else if (mon_r == '0 || mon_r > dcw_pkg::MONTH_DEC) begin
      status_c = dcw_pkg::ST_MONTH;
    end else if (day_r == '0 || day_r > mlen) begin
      status_c = dcw_pkg::ST_DAY;
    end else begin
      status_c = dcw_pkg::ST_OK;
    end
  end

  assign chk_ok = (status_c == dcw_pkg::ST_OK);

  // Shared add/subtract unit: one term per cycle into the accumulator.
  // 365p is built from shifted copies of p (256+64+32+8+4+1).
  always_comb begin
    op_a = acc_r;
    op_b = '0;
    sub  = 1'b0;
    case (ctrl.state)
      dcw_pkg::S_ACC: begin
        case (ctrl.step)
          4'd0:    op_b = CW'({p, 8'b0});
          4'd1:    op_b = CW'({p, 6'b0});
          4'd2:    op_b = CW'({p, 5'b0});
          4'd3:    op_b = CW'({p, 3'b0});
          4'd4:    op_b = CW'({p, 2'b0});
          4'd5:    op_b = CW'(p);
          4'd6:    op_b = CW'(p[YW-1:2]);
          4'd7: begin
            op_b = CW'(qp_r);
            sub  = 1'b1;
          end
          4'd8:    op_b = CW'(qp_r[dcw_pkg::QP_W-1:2]);
          4'd9: begin
            op_b = CW'(dcw_pkg::BASE_DAYS);
            sub  = 1'b1;
          end
          4'd10:   op_b = CW'(dcw_pkg::cum_days(mon_r))
                        + CW'(leap_r && mon_r > dcw_pkg::MONTH_FEB);
          4'd11:   op_b = CW'(day_r);
          default: op_b = '0;
        endcase
      end
      dcw_pkg::S_FOLD: begin
        if (ctrl.step == '0) begin
          op_b = CW'(dcw_pkg::WD_OFFSET);
        end else begin
          // 64 = 1 (mod 7): fold the upper bits onto the low six
          op_a = CW'(acc_r[CW-1:6]);
          op_b = CW'(acc_r[5:0]);
        end
      end
      default: begin
        op_a = acc_r;
      end
    endcase
    sum = sub ? (op_a - op_b) : (op_a + op_b);
  end

  always_comb begin
    day_nxt    = day_r;
    mon_nxt    = mon_r;
    year_nxt   = year_r;
    qp_nxt     = qp_r;
    leap_nxt   = leap_r;
    acc_nxt    = acc_r;
    status_nxt = status_r;
    count_nxt  = count_r;
    wd_nxt     = wd_r;
    case (ctrl.state)
      dcw_pkg::S_IDLE: begin
        if (in_tvalid) begin
          day_nxt  = day_of_month;
          mon_nxt  = month_number;
          year_nxt = year_number;
        end
      end
      dcw_pkg::S_DIV:  qp_nxt   = prod[dcw_pkg::PROD_W-1:dcw_pkg::RECIP_SH];
      dcw_pkg::S_LEAP: leap_nxt = y4 && (!y100 || y400);
      dcw_pkg::S_CHECK: begin
        status_nxt = status_c;
        count_nxt  = '0;
        wd_nxt     = '0;
        acc_nxt    = '0;
      end
      dcw_pkg::S_ACC: begin
        acc_nxt = sum;
        if (ctrl.step == dcw_pkg::STEP_W'(dcw_pkg::ACC_STEPS - 1)) begin
          count_nxt = sum;
        end
      end
      dcw_pkg::S_FOLD: begin
        acc_nxt = sum;
        if (ctrl.step == dcw_pkg::STEP_W'(dcw_pkg::FOLD_STEPS - 1)) begin
          wd_nxt = dcw_pkg::mod7(sum[6:0]);
        end
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  // Result register: take the finished date when the sequencer loads it
  always_comb begin
    res_status_nxt = res_status_r;
    res_count_nxt  = res_count_r;
    res_wd_nxt     = res_wd_r;
    if (ctrl.load) begin
      res_status_nxt = status_nxt;
      res_count_nxt  = count_nxt;
      res_wd_nxt     = wd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    day_r        <= day_nxt;
    mon_r        <= mon_nxt;
    year_r       <= year_nxt;
    qp_r         <= qp_nxt;
    leap_r       <= leap_nxt;
    acc_r        <= acc_nxt;
    status_r     <= status_nxt;
    count_r      <= count_nxt;
    wd_r         <= wd_nxt;
    res_status_r <= res_status_nxt;
    res_count_r  <= res_count_nxt;
    res_wd_r     <= res_wd_nxt;
  end

  assign status    = res_status_r;
  assign day_count = res_count_r;
  assign weekday   = res_wd_r;

endmodule

`default_nettype wire

[rtl/date_check_and_weekday.sv]
// ----------------------------------------------------------------------------
// date_check_and_weekday
// Checks a Gregorian date and, for a valid one, returns the day count since
// the epoch (1 Jan of the epoch year counts as 1) and the weekday.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake             Payload (lowest bit first)
//  -------   ---  --------------------  ---------------------------------------
//  in_       in   in_tvalid/in_tready   day_of_month[4:0] month_number[8:5]
//                                       year_number[22:9]
//  out_      out  out_tvalid/out_tready status[1:0] day_count[23:2]
//                                       weekday[26:24]
//
//  One date in work at a time, plus one finished result in the output
//  register. A valid date goes through divide, leap test and check, then
//  the single add/subtract unit takes one term a cycle, first for the count
//  and then for the mod-7 fold; an invalid date finishes at the check.
//  out_tvalid rises once the finished date is loaded into the result
//  register. in_tready returns as the result is loaded, so a new date is
//  taken only after the last one is finished. If the output register is
//  still full, hold the finished date and keep in_tready low until out_tready
//  frees it. Reset clears only the sequencer and the result-valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

`include "date_check_and_weekday_macros.svh"

module date_check_and_weekday (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: day_of_month[4:0], month_number[8:5], year_number[22:9], pad
  input  wire logic [23:0] in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata: status[1:0], day_count[23:2], weekday[26:24], pad
  output logic [31:0]      out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready
);

  dcw_pkg::dcw_ctrl_t                ctrl;
  logic                              chk_ok;
  dcw_pkg::status_t                  out_status;
  logic [dcw_pkg::CNT_W-1:0]         out_count;
  logic [dcw_pkg::WD_W-1:0]          out_wd;

  // Sequencer: owns the handshakes and the phase/step counters
  dcw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .chk_ok     (chk_ok),
    .ctrl       (ctrl)
  );

  // Datapath: capture on the input transfer, then work under ctrl
  dcw_dp u_dp (
    .clk          (clk),
    .ctrl         (ctrl),
    .in_tvalid    (in_tvalid),
    .day_of_month (in_tdata[4:0]),
    .month_number (in_tdata[8:5]),
    .year_number  (in_tdata[22:9]),
    .chk_ok       (chk_ok),
    .status       (out_status),
    .day_count    (out_count),
    .weekday      (out_wd)
  );

  // Pack the result; upper bits pad to a whole byte
  assign out_tdata = {5'b0, out_wd, out_count, out_status};

  // A rejected date carries no count and no weekday
  `DCW_ASSERT_IMPL(a_bad_date_zero, out_tvalid && out_status != dcw_pkg::ST_OK, out_count == '0 && out_wd == '0)
  // A good date has a nonzero count and a real weekday
  `DCW_ASSERT_IMPL(a_good_date_range, out_tvalid && out_status == dcw_pkg::ST_OK, out_count != '0 && out_wd < 3'd7)
  // A stalled result holds until its transfer
  `DCW_ASSERT_NEXT(a_hold_stalled, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // An input transfer always starts the divide phase
  `DCW_ASSERT_NEXT(a_start_divide, in_tvalid && in_tready, ctrl.state == dcw_pkg::S_DIV)

endmodule

`default_nettype wire
